// ===== src/bpm_pkg.sv =====
// Shared types, constants and the window average function for the breath pressure monitor.
`default_nettype none

package bpm_pkg;

  // Window geometry
  localparam int WINDOW_DEPTH = 8;
  localparam int LOG_D        = $clog2(WINDOW_DEPTH);
  localparam int POS_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam bit DIV_POW2     = ((WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0);

  // Entries are kept as 24-bit signed; clamped flow is never negative
  localparam int ENTRY_W = 24;
  localparam int SUM_W   = ENTRY_W + LOG_D;

  // Reciprocal for a depth that is not a power of two: exact for |sum| < 2**SUM_W
  localparam int RECIP_K = SUM_W + LOG_D;
  localparam int RECIP_W = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_K) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

  // Op codes
  localparam logic [2:0] OP_INH       = 3'd0;
  localparam logic [2:0] OP_EXH       = 3'd1;
  localparam logic [2:0] OP_START     = 3'd2;
  localparam logic [2:0] OP_HIGH      = 3'd3;
  localparam logic [2:0] OP_LOW       = 3'd4;
  localparam logic [2:0] OP_CLR_INH   = 3'd5;

  // Config register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_START = 2'd1;

  localparam logic signed [15:0] PRESS_MIN = 16'sh8000;
  localparam logic [14:0]        COUNT_MAX = 15'h7fff;

  typedef struct packed {
    logic wr;
    logic clr;
  } win_ctrl_t;

  typedef struct packed {
    logic inh;
    logic exh;
    logic start;
  } stats_ctrl_t;

  typedef struct packed {
    logic signed [15:0] peak;
    logic signed [31:0] total;
    logic [14:0]        inh_cnt;
    logic [14:0]        exh_cnt;
  } stats_t;

  typedef struct packed {
    logic signed [15:0] peak_inh_pressure;
    logic signed [15:0] end_inh_pressure;
    logic [14:0]        end_inh_pressure_comp;
    logic signed [15:0] end_exh_pressure;
    logic signed [15:0] high_phase_pressure;
    logic signed [15:0] low_phase_pressure;
    logic signed [31:0] pressure_total;
    logic [14:0]        inh_samples;
    logic [14:0]        exh_samples;
    logic [22:0]        end_inh_flow;
    logic [22:0]        end_exh_flow;
  } res_t;

  // Window sum / depth, truncated toward zero
  function automatic logic signed [ENTRY_W-1:0] win_avg(input logic signed [SUM_W-1:0] s);
    logic                       neg;
    logic [SUM_W-1:0]           mag;
    logic [SUM_W+RECIP_W-1:0]   prod;
    logic [SUM_W-1:0]           q;
    neg  = s[SUM_W-1];
    mag  = neg ? $unsigned(-s) : $unsigned(s);
    prod = '0;
    if (DIV_POW2) begin
      q = mag >> LOG_D;
    end else begin
      prod = mag * RECIP;
      q    = SUM_W'(prod >> RECIP_K);
    end
    win_avg = neg ? -$signed(ENTRY_W'(q)) : $signed(ENTRY_W'(q));
  endfunction

endpackage

`default_nettype wire

// ===== src/bpm_window.sv =====
// Last-N sample window with running sum.
`default_nettype none

module bpm_window (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  bpm_pkg::win_ctrl_t                      ctrl_i,
  input  logic signed [bpm_pkg::ENTRY_W-1:0]      data_i,
  output logic signed [bpm_pkg::SUM_W-1:0]        sum_o
);

  logic signed [bpm_pkg::ENTRY_W-1:0] entry_q [bpm_pkg::WINDOW_DEPTH];
  logic [bpm_pkg::POS_W-1:0]          pos_q, pos_d;
  logic signed [bpm_pkg::SUM_W-1:0]   sum_q, sum_d;

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (ctrl_i.clr) begin
      pos_d = '0;
      sum_d = '0;
    end else if (ctrl_i.wr) begin
      // replace the oldest entry
      sum_d = sum_q - bpm_pkg::SUM_W'(entry_q[pos_q]) + bpm_pkg::SUM_W'(data_i);
      pos_d = (pos_q == bpm_pkg::POS_W'(bpm_pkg::WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      for (int i = 0; i < bpm_pkg::WINDOW_DEPTH; i++) begin
        entry_q[i] <= '0;
      end
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      if (ctrl_i.clr) begin
        for (int i = 0; i < bpm_pkg::WINDOW_DEPTH; i++) begin
          entry_q[i] <= '0;
        end
      end else if (ctrl_i.wr) begin
        entry_q[pos_q] <= data_i;
      end
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== src/bpm_stats.sv =====
// Peak pressure, saturating pressure sum and sample counters.
`default_nettype none

module bpm_stats (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpm_pkg::stats_ctrl_t  ctrl_i,
  input  logic signed [15:0]    pressure_i,
  input  logic signed [15:0]    peak_start_i,
  output bpm_pkg::stats_t       stats_o
);

  bpm_pkg::stats_t    st_q, st_d;
  logic signed [32:0] acc_sum;

  always_comb begin
    st_d    = st_q;
    acc_sum = 33'(st_q.total) + 33'(pressure_i);
    if (ctrl_i.start) begin
      st_d.peak    = peak_start_i;
      st_d.total   = '0;
      st_d.inh_cnt = '0;
      st_d.exh_cnt = '0;
    end else if (ctrl_i.inh || ctrl_i.exh) begin
      // saturate at 32-bit signed limits
      if (acc_sum[32] != acc_sum[31]) begin
        st_d.total = acc_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        st_d.total = acc_sum[31:0];
      end
      if (ctrl_i.inh) begin
        if (pressure_i > st_q.peak) st_d.peak = pressure_i;
        if (st_q.inh_cnt != bpm_pkg::COUNT_MAX) st_d.inh_cnt = st_q.inh_cnt + 1'b1;
      end else begin
        if (st_q.exh_cnt != bpm_pkg::COUNT_MAX) st_d.exh_cnt = st_q.exh_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.peak    <= bpm_pkg::PRESS_MIN;
      st_q.total   <= '0;
      st_q.inh_cnt <= '0;
      st_q.exh_cnt <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign stats_o = st_q;

endmodule

`default_nettype wire

// ===== src/bpm_out.sv =====
// Averages, baseline compensation and the result register.
`default_nettype none

module bpm_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic                               out_ready_i,
  input  logic signed [bpm_pkg::SUM_W-1:0]   inh_press_sum_i,
  input  logic signed [bpm_pkg::SUM_W-1:0]   exh_press_sum_i,
  input  logic signed [bpm_pkg::SUM_W-1:0]   high_sum_i,
  input  logic signed [bpm_pkg::SUM_W-1:0]   low_sum_i,
  input  logic signed [bpm_pkg::SUM_W-1:0]   inh_flow_sum_i,
  input  logic signed [bpm_pkg::SUM_W-1:0]   exh_flow_sum_i,
  input  bpm_pkg::stats_t                    stats_i,
  input  logic [14:0]                        baseline_i,
  output logic                               out_valid_o,
  output bpm_pkg::res_t                      res_o
);

  logic signed [bpm_pkg::ENTRY_W-1:0] inh_avg, exh_avg, high_avg, low_avg;
  logic signed [bpm_pkg::ENTRY_W-1:0] inh_flow_avg, exh_flow_avg;
  logic signed [16:0]                 comp_diff;
  bpm_pkg::res_t                      res_d, res_q;
  logic                               valid_q, valid_d;

  always_comb begin
    inh_avg      = bpm_pkg::win_avg(inh_press_sum_i);
    exh_avg      = bpm_pkg::win_avg(exh_press_sum_i);
    high_avg     = bpm_pkg::win_avg(high_sum_i);
    low_avg      = bpm_pkg::win_avg(low_sum_i);
    inh_flow_avg = bpm_pkg::win_avg(inh_flow_sum_i);
    exh_flow_avg = bpm_pkg::win_avg(exh_flow_sum_i);
    comp_diff    = 17'($signed(inh_avg[15:0])) - $signed({2'b00, baseline_i});

    res_d.peak_inh_pressure     = stats_i.peak;
    res_d.end_inh_pressure      = inh_avg[15:0];
    res_d.end_inh_pressure_comp = comp_diff[16] ? '0 : comp_diff[14:0];
    res_d.end_exh_pressure      = exh_avg[15:0];
    res_d.high_phase_pressure   = high_avg[15:0];
    res_d.low_phase_pressure    = low_avg[15:0];
    res_d.pressure_total        = stats_i.total;
    res_d.inh_samples           = stats_i.inh_cnt;
    res_d.exh_samples           = stats_i.exh_cnt;
    res_d.end_inh_flow          = inh_flow_avg[22:0];
    res_d.end_exh_flow          = exh_flow_avg[22:0];

    valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== src/breath_pressure_monitor_core.sv =====
// Top level of the breath pressure monitor: handshake, config registers, op decode.
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one word per control cycle:
//    op_i, pressure_i, net_flow_i. The op selects inhalation, exhalation,
//    breath start, APRV high, APRV low or clear of the inhalation pressure window.
//  - Output channel (out_valid_o/out_ready_i) returns one word per input word:
//    peak, window averages, compensated end inhalation pressure, totals, counts.
//  - Config channel (cfg_valid_i/cfg_ready_o) writes baseline_pressure (index 0)
//    and peak_start_value (index 1); other indexes are dropped. Always ready.
//    Write only while no word is in flight.
//  - Timing: state updates at the accept edge; the result register loads from the
//    state registers once it is empty or being read, and out_valid_o rises with that load.
//  - Throughput: one word per cycle while the receiver keeps up. Running
//    window sums keep each update to one add/subtract; the average is a
//    shift (or a reciprocal multiply) in the result stage.
//  - Receiver stall: one finished word waits in the result register while the
//    next accepted word sits in the state registers; in_ready_o drops only
//    when both are held.
//  - Reset: windows, sums and counts zero, peak -32768, baseline 0,
//    peak start -32768, no word pending.
`default_nettype none

module breath_pressure_monitor_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        op_i,
  input  logic signed [15:0]                pressure_i,
  input  logic signed [23:0]                net_flow_i,
  // config writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [15:0]                       cfg_data_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [15:0]                peak_inh_pressure_o,
  output logic signed [15:0]                end_inh_pressure_o,
  output logic [14:0]                       end_inh_pressure_comp_o,
  output logic signed [15:0]                end_exh_pressure_o,
  output logic signed [15:0]                high_phase_pressure_o,
  output logic signed [15:0]                low_phase_pressure_o,
  output logic signed [31:0]                pressure_total_o,
  output logic [14:0]                       inh_samples_o,
  output logic [14:0]                       exh_samples_o,
  output logic [22:0]                       end_inh_flow_o,
  output logic [22:0]                       end_exh_flow_o
);

  logic                  in_acc;
  logic                  pend_q, pend_d;   // state holds an item not yet in the result reg
  logic                  adv;
  logic [14:0]           baseline_q;
  logic signed [15:0]    peak_start_q;

  logic signed [bpm_pkg::ENTRY_W-1:0] press_ext, flow_clamp;

  bpm_pkg::win_ctrl_t    inh_press_ctrl, inh_flow_ctrl, exh_ctrl, high_ctrl, low_ctrl;
  bpm_pkg::stats_ctrl_t  stats_ctrl;
  bpm_pkg::stats_t       stats;
  bpm_pkg::res_t         res;

  logic signed [bpm_pkg::SUM_W-1:0] inh_press_sum, exh_press_sum, high_sum, low_sum;
  logic signed [bpm_pkg::SUM_W-1:0] inh_flow_sum, exh_flow_sum;

  // Handshake: state stage feeds the result register
  assign adv        = pend_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !pend_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pend_d     = in_acc ? 1'b1 : (adv ? 1'b0 : pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q   <= '0;
      peak_start_q <= bpm_pkg::PRESS_MIN;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bpm_pkg::REG_BASELINE) begin
        baseline_q <= cfg_data_i[14:0];
      end else if (cfg_index_i == bpm_pkg::REG_PEAK_START) begin
        peak_start_q <= cfg_data_i;
      end
    end
  end

  // Sample formatting: flow below zero stores as zero
  assign press_ext  = bpm_pkg::ENTRY_W'(pressure_i);
  assign flow_clamp = net_flow_i[23] ? '0 : net_flow_i;

  // Op decode
  always_comb begin
    inh_press_ctrl = '0;
    inh_flow_ctrl  = '0;
    exh_ctrl       = '0;
    high_ctrl      = '0;
    low_ctrl       = '0;
    stats_ctrl     = '0;
    if (in_acc) begin
      unique case (op_i)
        bpm_pkg::OP_INH: begin
          inh_press_ctrl.wr = 1'b1;
          inh_flow_ctrl.wr  = 1'b1;
          stats_ctrl.inh    = 1'b1;
        end
        bpm_pkg::OP_EXH: begin
          exh_ctrl.wr    = 1'b1;
          stats_ctrl.exh = 1'b1;
        end
        bpm_pkg::OP_START: begin
          // low window survives a breath start
          inh_press_ctrl.clr = 1'b1;
          inh_flow_ctrl.clr  = 1'b1;
          exh_ctrl.clr       = 1'b1;
          high_ctrl.clr      = 1'b1;
          stats_ctrl.start   = 1'b1;
        end
        bpm_pkg::OP_HIGH:    high_ctrl.wr       = 1'b1;
        bpm_pkg::OP_LOW:     low_ctrl.wr        = 1'b1;
        bpm_pkg::OP_CLR_INH: inh_press_ctrl.clr = 1'b1;
        default: ;
      endcase
    end
  end

  bpm_window u_inh_press (
    .clk_i, .rst_ni, .ctrl_i(inh_press_ctrl), .data_i(press_ext), .sum_o(inh_press_sum)
  );

  bpm_window u_inh_flow (
    .clk_i, .rst_ni, .ctrl_i(inh_flow_ctrl), .data_i(flow_clamp), .sum_o(inh_flow_sum)
  );

  bpm_window u_exh_press (
    .clk_i, .rst_ni, .ctrl_i(exh_ctrl), .data_i(press_ext), .sum_o(exh_press_sum)
  );

  bpm_window u_exh_flow (
    .clk_i, .rst_ni, .ctrl_i(exh_ctrl), .data_i(flow_clamp), .sum_o(exh_flow_sum)
  );

  bpm_window u_high (
    .clk_i, .rst_ni, .ctrl_i(high_ctrl), .data_i(press_ext), .sum_o(high_sum)
  );

  bpm_window u_low (
    .clk_i, .rst_ni, .ctrl_i(low_ctrl), .data_i(press_ext), .sum_o(low_sum)
  );

  bpm_stats u_stats (
    .clk_i,
    .rst_ni,
    .ctrl_i      (stats_ctrl),
    .pressure_i  (pressure_i),
    .peak_start_i(peak_start_q),
    .stats_o     (stats)
  );

  bpm_out u_out (
    .clk_i,
    .rst_ni,
    .load_i         (adv),
    .out_ready_i    (out_ready_i),
    .inh_press_sum_i(inh_press_sum),
    .exh_press_sum_i(exh_press_sum),
    .high_sum_i     (high_sum),
    .low_sum_i      (low_sum),
    .inh_flow_sum_i (inh_flow_sum),
    .exh_flow_sum_i (exh_flow_sum),
    .stats_i        (stats),
    .baseline_i     (baseline_q),
    .out_valid_o    (out_valid_o),
    .res_o          (res)
  );

  assign peak_inh_pressure_o     = res.peak_inh_pressure;
  assign end_inh_pressure_o      = res.end_inh_pressure;
  assign end_inh_pressure_comp_o = res.end_inh_pressure_comp;
  assign end_exh_pressure_o      = res.end_exh_pressure;
  assign high_phase_pressure_o   = res.high_phase_pressure;
  assign low_phase_pressure_o    = res.low_phase_pressure;
  assign pressure_total_o        = res.pressure_total;
  assign inh_samples_o           = res.inh_samples;
  assign exh_samples_o           = res.exh_samples;
  assign end_inh_flow_o          = res.end_inh_flow;
  assign end_exh_flow_o          = res.end_exh_flow;

endmodule

`default_nettype wire

// ===== tb/tb_breath_pressure_monitor_core.sv =====
// Self-checking testbench for breath_pressure_monitor_core with a cycle-free behavioral predictor.
module tb_breath_pressure_monitor_core;

  // Spare op codes: the block must leave its state alone and just report it
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Register indexes with no register behind them
  localparam logic [bpm_pkg::CFG_IDX_W-1:0] REG_NONE_2 = 2'd2;
  localparam logic [bpm_pkg::CFG_IDX_W-1:0] REG_NONE_3 = 2'd3;

  // Predictor window slots
  localparam int W_INH_P = 0;
  localparam int W_EXH_P = 1;
  localparam int W_INH_F = 2;
  localparam int W_EXH_F = 3;
  localparam int W_HIGH  = 4;
  localparam int W_LOW   = 5;

  // Sender pacing styles
  localparam int GAP_NORMAL = 0;
  localparam int GAP_CALM   = 1;
  localparam int GAP_BURST  = 2;

  // Settle time after a drain (doubled at the end of the run); the result is registered after the accept edge
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_WORDS  = 1400;

  typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_DRAIN} act_kind_e;

  typedef struct {
    act_kind_e          kind;
    logic [2:0]         op;
    logic signed [15:0] pressure;
    logic signed [23:0] flow;
    logic [1:0]         idx;
    logic [15:0]        data;
    int                 gap;
  } script_step_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              in_valid_i  = 1'b0;
  logic                              in_ready_o;
  logic [2:0]                        op_i        = bpm_pkg::OP_INH;
  logic signed [15:0]                pressure_i  = '0;
  logic signed [23:0]                net_flow_i  = '0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [bpm_pkg::CFG_IDX_W-1:0]     cfg_index_i = bpm_pkg::REG_BASELINE;
  logic [15:0]                       cfg_data_i  = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic signed [15:0]                peak_inh_pressure_o;
  logic signed [15:0]                end_inh_pressure_o;
  logic [14:0]                       end_inh_pressure_comp_o;
  logic signed [15:0]                end_exh_pressure_o;
  logic signed [15:0]                high_phase_pressure_o;
  logic signed [15:0]                low_phase_pressure_o;
  logic signed [31:0]                pressure_total_o;
  logic [14:0]                       inh_samples_o;
  logic [14:0]                       exh_samples_o;
  logic [22:0]                       end_inh_flow_o;
  logic [22:0]                       end_exh_flow_o;

  always #5 clk_i = ~clk_i;

  breath_pressure_monitor_core dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .op_i                    (op_i),
    .pressure_i              (pressure_i),
    .net_flow_i              (net_flow_i),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .peak_inh_pressure_o     (peak_inh_pressure_o),
    .end_inh_pressure_o      (end_inh_pressure_o),
    .end_inh_pressure_comp_o (end_inh_pressure_comp_o),
    .end_exh_pressure_o      (end_exh_pressure_o),
    .high_phase_pressure_o   (high_phase_pressure_o),
    .low_phase_pressure_o    (low_phase_pressure_o),
    .pressure_total_o        (pressure_total_o),
    .inh_samples_o           (inh_samples_o),
    .exh_samples_o           (exh_samples_o),
    .end_inh_flow_o          (end_inh_flow_o),
    .end_exh_flow_o          (end_exh_flow_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the block's registers, windows kept as plain ints
  // ---------------------------------------------------------------------------
  int                 baseline_model   = 0;
  logic signed [15:0] peak_start_model = bpm_pkg::PRESS_MIN;
  logic signed [15:0] peak_model       = bpm_pkg::PRESS_MIN;
  longint             total_model;
  int                 inh_count_model;
  int                 exh_count_model;
  longint             win [6][bpm_pkg::WINDOW_DEPTH];
  int                 pos_inh_p, pos_inh_f, pos_exh, pos_high, pos_low;

  // Bookkeeping
  script_step_t  sample_script[$];     // words, register writes and drain points
  bpm_pkg::res_t expected_readings[$]; // predicted result words, oldest first
  int            scripted_words;
  int            gap_style = GAP_NORMAL;
  int            fails;
  int            readings_checked;
  int            reg_writes;
  int            op_tally [8];

  // Handshake flags seen at the last rising edge, used by the falling-edge drivers
  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;

  // Sender state
  int gap_left;
  bit draining;
  int settle_left;

  // Receiver state
  int ready_left;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint window_mean(input int w);
    longint s;
    s = 0;
    for (int j = 0; j < bpm_pkg::WINDOW_DEPTH; j++) s += win[w][j];
    return s / bpm_pkg::WINDOW_DEPTH;  // signed divide truncates toward zero
  endfunction

  function automatic longint sat_total(input longint t);
    if (t > 64'sd2147483647) return 64'sd2147483647;
    if (t < -64'sd2147483648) return -64'sd2147483648;
    return t;
  endfunction

  function automatic int next_slot(input int p);
    return (p + 1 >= bpm_pkg::WINDOW_DEPTH) ? 0 : p + 1;
  endfunction

  // Applies one word to the model and returns the reading the block must report
  function automatic bpm_pkg::res_t breath_update(input logic [2:0] op,
                                                  input logic signed [15:0] p,
                                                  input logic signed [23:0] fl);
    longint        f;
    longint        ia;
    longint        comp;
    bpm_pkg::res_t r;
    f = (fl < 0) ? 0 : longint'(fl);
    case (op)
      bpm_pkg::OP_INH: begin
        if (p > peak_model) peak_model = p;
        total_model = sat_total(total_model + p);
        if (inh_count_model < bpm_pkg::COUNT_MAX) inh_count_model++;
        win[W_INH_P][pos_inh_p] = p;
        pos_inh_p = next_slot(pos_inh_p);
        win[W_INH_F][pos_inh_f] = f;
        pos_inh_f = next_slot(pos_inh_f);
      end
      bpm_pkg::OP_EXH: begin
        total_model = sat_total(total_model + p);
        if (exh_count_model < bpm_pkg::COUNT_MAX) exh_count_model++;
        win[W_EXH_P][pos_exh] = p;
        win[W_EXH_F][pos_exh] = f;
        pos_exh = next_slot(pos_exh);
      end
      bpm_pkg::OP_START: begin
        // low window and both APRV positions survive a breath start
        peak_model      = peak_start_model;
        total_model     = 0;
        inh_count_model = 0;
        exh_count_model = 0;
        for (int j = 0; j < bpm_pkg::WINDOW_DEPTH; j++) begin
          win[W_INH_P][j] = 0;
          win[W_EXH_P][j] = 0;
          win[W_INH_F][j] = 0;
          win[W_EXH_F][j] = 0;
          win[W_HIGH][j]  = 0;
        end
        pos_inh_p = 0;
        pos_inh_f = 0;
        pos_exh   = 0;
      end
      bpm_pkg::OP_HIGH: begin
        win[W_HIGH][pos_high] = p;
        pos_high = next_slot(pos_high);
      end
      bpm_pkg::OP_LOW: begin
        win[W_LOW][pos_low] = p;
        pos_low = next_slot(pos_low);
      end
      bpm_pkg::OP_CLR_INH: begin
        for (int j = 0; j < bpm_pkg::WINDOW_DEPTH; j++) win[W_INH_P][j] = 0;
        pos_inh_p = 0;
      end
      default: ;
    endcase
    ia   = window_mean(W_INH_P);
    comp = ia - baseline_model;
    if (comp < 0) comp = 0;
    r.peak_inh_pressure     = peak_model;
    r.end_inh_pressure      = 16'(ia);
    r.end_inh_pressure_comp = 15'(comp);
    r.end_exh_pressure      = 16'(window_mean(W_EXH_P));
    r.high_phase_pressure   = 16'(window_mean(W_HIGH));
    r.low_phase_pressure    = 16'(window_mean(W_LOW));
    r.pressure_total        = 32'(total_model);
    r.inh_samples           = 15'(inh_count_model);
    r.exh_samples           = 15'(exh_count_model);
    r.end_inh_flow          = 23'(window_mean(W_INH_F));
    r.end_exh_flow          = 23'(window_mean(W_EXH_F));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_reading(input bpm_pkg::res_t want);
    check_field("peak_inh_pressure", want.peak_inh_pressure, peak_inh_pressure_o);
    check_field("end_inh_pressure", want.end_inh_pressure, end_inh_pressure_o);
    check_field("end_inh_pressure_comp", want.end_inh_pressure_comp, end_inh_pressure_comp_o);
    check_field("end_exh_pressure", want.end_exh_pressure, end_exh_pressure_o);
    check_field("high_phase_pressure", want.high_phase_pressure, high_phase_pressure_o);
    check_field("low_phase_pressure", want.low_phase_pressure, low_phase_pressure_o);
    check_field("pressure_total", want.pressure_total, pressure_total_o);
    check_field("inh_samples", want.inh_samples, inh_samples_o);
    check_field("exh_samples", want.exh_samples, exh_samples_o);
    check_field("end_inh_flow", want.end_inh_flow, end_inh_flow_o);
    check_field("end_exh_flow", want.end_exh_flow, end_exh_flow_o);
  endtask

  // Monitor: everything is sampled at the rising edge. Results are popped before
  // the new word is predicted so a stray result can never match its own word.
  always @(posedge clk_i) begin : monitor
    bpm_pkg::res_t want;
    in_taken  <= in_valid_i && in_ready_o;
    cfg_taken <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          fails++;
          $display("%0t: result word with none expected, expected nothing, actual total %0h",
                   $time, pressure_total_o);
        end else begin
          want = expected_readings.pop_front();
          compare_reading(want);
          readings_checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        reg_writes++;
        if (cfg_index_i == bpm_pkg::REG_BASELINE) baseline_model = int'(cfg_data_i[14:0]);
        else if (cfg_index_i == bpm_pkg::REG_PEAK_START) peak_start_model = $signed(cfg_data_i);
      end
      if (in_valid_i && in_ready_o) begin
        op_tally[op_i]++;
        expected_readings.push_back(breath_update(op_i, pressure_i, net_flow_i));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pacing helpers: mostly short gaps, a few long ones
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int word_gap();
    if (gap_style == GAP_CALM) return 0;
    if (gap_style == GAP_BURST) return ($urandom_range(0, 63) == 0) ? $urandom_range(1, 3) : 0;
    return ($urandom_range(0, 99) < 55) ? 0 : idle_len();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: launches the next script step at the falling edge once the
  // current word is gone. Exactly one nonblocking write per valid per edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : sender
    script_step_t step;
    logic         nxt_in;
    logic         nxt_cfg;
    if (rst_ni) begin
      nxt_in  = in_valid_i && !in_taken;
      nxt_cfg = cfg_valid_i && !cfg_taken;
      if (!nxt_in && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (draining) begin
          // hold off until every reading has come back, then let the pipe settle
          if (expected_readings.size() == 0) begin
            if (settle_left > 0) settle_left--;
            else draining = 1'b0;
          end
        end else if (sample_script.size() > 0) begin
          step = sample_script.pop_front();
          case (step.kind)
            ACT_WORD: begin
              nxt_in     = 1'b1;
              op_i       <= step.op;
              pressure_i <= step.pressure;
              net_flow_i <= step.flow;
              gap_left   = step.gap;
            end
            ACT_CFG: begin
              nxt_cfg     = 1'b1;
              cfg_index_i <= step.idx;
              cfg_data_i  <= step.data;
            end
            default: begin
              draining    = 1'b1;
              settle_left = SETTLE_CYCLES;
            end
          endcase
        end
      end
      in_valid_i  <= nxt_in;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // Receiver: random stalls, with occasional long stretches of steady ready
  always @(negedge clk_i) begin : receiver
    int r;
    if (rst_ni) begin
      if (ready_left > 0) begin
        ready_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_ready_i <= 1'b1;
          ready_left  = $urandom_range(50, 300);
        end else if (r < 70) begin
          out_ready_i <= 1'b1;
          ready_left  = $urandom_range(0, 6);
        end else begin
          out_ready_i <= 1'b0;
          ready_left  = idle_len();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Script building
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [2:0] op, input logic signed [15:0] p,
                           input logic signed [23:0] f);
    script_step_t s;
    s.kind     = ACT_WORD;
    s.op       = op;
    s.pressure = p;
    s.flow     = f;
    s.idx      = '0;
    s.data     = '0;
    s.gap      = word_gap();
    sample_script.push_back(s);
    scripted_words++;
  endtask

  task automatic push_drain();
    script_step_t s;
    s.kind     = ACT_DRAIN;
    s.op       = bpm_pkg::OP_INH;
    s.pressure = '0;
    s.flow     = '0;
    s.idx      = '0;
    s.data     = '0;
    s.gap      = 0;
    sample_script.push_back(s);
  endtask

  // Register writes only go out once the block has drained
  task automatic push_cfg(input logic [bpm_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    script_step_t s;
    push_drain();
    s.kind     = ACT_CFG;
    s.op       = bpm_pkg::OP_INH;
    s.pressure = '0;
    s.flow     = '0;
    s.idx      = idx;
    s.data     = data;
    s.gap      = 0;
    sample_script.push_back(s);
  endtask

  function automatic logic signed [15:0] rand_pressure();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    if (r < 5) return 16'(int'($urandom_range(0, 2400)) - 400);
    return 16'($urandom);
  endfunction

  function automatic logic signed [23:0] rand_flow();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
    if (r < 5) return 24'(int'($urandom_range(0, 120000)) - 20000);
    return 24'($urandom);
  endfunction

  function automatic logic [15:0] rand_reg_value();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h7fff;
      3:       return 16'h8000;
      4:       return 16'($urandom_range(0, 600));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_config();
    push_cfg(bpm_pkg::REG_BASELINE, rand_reg_value());
    push_cfg(bpm_pkg::REG_PEAK_START, rand_reg_value());
    if ($urandom_range(0, 3) == 0)
      push_cfg($urandom_range(0, 1) ? REG_NONE_2 : REG_NONE_3, 16'($urandom));
  endtask

  // One ventilator breath: start, inhalation, optional window clear and APRV
  // samples, then exhalation
  task automatic push_breath();
    push_word(bpm_pkg::OP_START, rand_pressure(), rand_flow());
    repeat ($urandom_range(1, 20)) push_word(bpm_pkg::OP_INH, rand_pressure(), rand_flow());
    if ($urandom_range(0, 5) == 0) begin
      push_word(bpm_pkg::OP_CLR_INH, rand_pressure(), rand_flow());
      repeat ($urandom_range(0, 4)) push_word(bpm_pkg::OP_INH, rand_pressure(), rand_flow());
    end
    repeat ($urandom_range(0, 3))
      push_word($urandom_range(0, 1) ? bpm_pkg::OP_HIGH : bpm_pkg::OP_LOW,
                rand_pressure(), rand_flow());
    repeat ($urandom_range(1, 20)) push_word(bpm_pkg::OP_EXH, rand_pressure(), rand_flow());
  endtask

  task automatic build_script();
    int r;
    int random_from;
    int next_cfg_at;

    // Directed: field extremes and every op at reset settings
    push_word(bpm_pkg::OP_INH, 16'sh7fff, 24'sh7fffff);
    push_word(bpm_pkg::OP_INH, 16'sh8000, 24'sh800000);
    push_word(bpm_pkg::OP_INH, 16'sh0000, 24'sh000000);
    push_word(bpm_pkg::OP_EXH, 16'sh7fff, 24'sh7fffff);
    push_word(bpm_pkg::OP_EXH, 16'sh8000, 24'shffffff);
    push_word(bpm_pkg::OP_HIGH, 16'sh7fff, 24'sh000001);
    push_word(bpm_pkg::OP_HIGH, 16'sh8000, 24'sh800000);
    push_word(bpm_pkg::OP_LOW, 16'sh7fff, 24'sh7fffff);
    push_word(bpm_pkg::OP_LOW, 16'sh8000, 24'sh000000);
    push_word(bpm_pkg::OP_CLR_INH, 16'sh1234, 24'sh123456);
    push_word(OP_SPARE_6, 16'sh7fff, 24'sh7fffff);
    push_word(OP_SPARE_7, 16'sh8000, 24'sh800000);
    push_word(bpm_pkg::OP_START, 16'sh0000, 24'sh000000);

    // Largest baseline (bit 15 of the data must be dropped), peak restarts high,
    // writes to empty indexes must change nothing
    push_cfg(bpm_pkg::REG_BASELINE, 16'hffff);
    push_cfg(bpm_pkg::REG_PEAK_START, 16'h7fff);
    push_cfg(REG_NONE_2, 16'h1234);
    push_cfg(REG_NONE_3, 16'hffff);
    push_word(bpm_pkg::OP_START, 16'sh0000, 24'sh000000);
    push_word(bpm_pkg::OP_INH, 16'sh0064, 24'sh000010);
    // fill and wrap the inhalation windows
    repeat (bpm_pkg::WINDOW_DEPTH + 1) push_word(bpm_pkg::OP_INH, 16'sh7fff, 24'sh7fffff);

    // Negative averages must truncate toward zero
    push_cfg(bpm_pkg::REG_BASELINE, 16'h0000);
    push_cfg(bpm_pkg::REG_PEAK_START, 16'h8000);
    push_word(bpm_pkg::OP_START, 16'sh0000, 24'sh000000);
    push_word(bpm_pkg::OP_INH, -16'sd5, -24'sd5);
    push_word(bpm_pkg::OP_INH, -16'sd3, 24'sd3);
    push_word(bpm_pkg::OP_EXH, -16'sd7, 24'sd9);

    // Back-to-back bursts at full-scale pressure of both signs
    gap_style = GAP_BURST;
    push_word(bpm_pkg::OP_START, 16'sh0000, 24'sh000000);
    repeat (24) push_word(bpm_pkg::OP_INH, 16'sh7fff, rand_flow());
    repeat (24) push_word(bpm_pkg::OP_EXH, 16'sh7fff, rand_flow());
    push_word(bpm_pkg::OP_START, 16'sh0000, 24'sh000000);
    repeat (24)
      push_word($urandom_range(0, 1) ? bpm_pkg::OP_INH : bpm_pkg::OP_EXH, 16'sh8000,
                rand_flow());
    push_drain();

    // Random: mostly whole breaths, some APRV runs, some noise
    random_from = scripted_words;
    next_cfg_at = 0;
    while (scripted_words - random_from < RANDOM_WORDS) begin
      if (scripted_words - random_from >= next_cfg_at) begin
        random_config();
        next_cfg_at += $urandom_range(150, 300);
      end
      gap_style = ($urandom_range(0, 4) == 0) ? GAP_CALM : GAP_NORMAL;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_breath();
      end else if (r < 82) begin
        repeat ($urandom_range(1, 12))
          push_word($urandom_range(0, 1) ? bpm_pkg::OP_HIGH : bpm_pkg::OP_LOW,
                    rand_pressure(), rand_flow());
      end else if (r < 97) begin
        repeat ($urandom_range(1, 10))
          push_word(3'($urandom_range(0, 7)), rand_pressure(), rand_flow());
      end else begin
        push_drain();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  initial begin
    build_script();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (!(sample_script.size() == 0 && !in_valid_i && !cfg_valid_i && !draining &&
             expected_readings.size() == 0));
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d words: inh %0d, exh %0d, start %0d, high %0d, low %0d,",
             op_tally.sum(), op_tally[bpm_pkg::OP_INH], op_tally[bpm_pkg::OP_EXH],
             op_tally[bpm_pkg::OP_START], op_tally[bpm_pkg::OP_HIGH],
             op_tally[bpm_pkg::OP_LOW]);
    $display("  clear %0d, spare %0d; compared %0d readings, %0d register writes, %0d mismatches",
             op_tally[bpm_pkg::OP_CLR_INH], op_tally[OP_SPARE_6] + op_tally[OP_SPARE_7],
             readings_checked, reg_writes, fails);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(64'd50_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
